### hdl/iqpm_pkg.sv
`default_nettype none

package iqpm_pkg;

    localparam int SUM_W       = 48;
    localparam int RSSI_W      = 16;
    localparam int CNT_OUT_W   = 17;
    // 10*log10(2) in Q.16, scales a log2 difference into dB.
    localparam int DB_PER_LOG2 = 197283;

    localparam logic signed [RSSI_W-1:0] OFFSET_RESET = -16'sd10625;
    localparam logic signed [RSSI_W-1:0] RSSI_MAX     = 16'sh7fff;
    localparam logic signed [RSSI_W-1:0] RSSI_MIN     = 16'sh8000;

    // Buffer information that travels alongside the log2 pipelines.
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [CNT_OUT_W-1:0] count;
    } side_t;

    typedef struct packed {
        logic [RSSI_W-1:0]    rssi;
        logic [CNT_OUT_W-1:0] count;
        logic                 zero;
    } result_t;

    // round(65536 * log2(1 + k/16)) for k = 0..16.
    function automatic logic [16:0] log_tab(input logic [4:0] k);
        logic [16:0] val;
        case (k)
            5'd0:    val = 17'd0;
            5'd1:    val = 17'd5732;
            5'd2:    val = 17'd11136;
            5'd3:    val = 17'd16248;
            5'd4:    val = 17'd21098;
            5'd5:    val = 17'd25711;
            5'd6:    val = 17'd30109;
            5'd7:    val = 17'd34312;
            5'd8:    val = 17'd38336;
            5'd9:    val = 17'd42196;
            5'd10:   val = 17'd45904;
            5'd11:   val = 17'd49472;
            5'd12:   val = 17'd52911;
            5'd13:   val = 17'd56229;
            5'd14:   val = 17'd59434;
            5'd15:   val = 17'd62534;
            5'd16:   val = 17'd65536;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hdl/iq_rssi_power_meter_unit.sv
// Average power meter for complex IQ samples. One sample is taken per clock unless stalled;
// each sample adds I*I+Q*Q to a 48-bit saturating sum and is counted. The sample flagged
// last_of_buffer closes the buffer and presents rssi_db = 10*log10(sum/count) plus offset_db
// in signed Q8.8, saturated, together with the sample count. Both logarithms come from a
// four-stage log2 unit (leading-one encode, normalize, table interpolation, combine) followed
// by a subtract, a constant multiply and a round/clamp stage. A zero sum reports -32768 with
// power_zero set. Once MAX_SAMPLES samples are counted, further samples are ignored until
// the closing one. Results queue in an output register plus a skid register, so the input
// keeps flowing while one result waits; sample_stall rises only when both hold results. Write
// offset_db through offset_we only while no buffer result is pending; it is not enforced.
`default_nettype none

module iq_rssi_power_meter_unit
    import iqpm_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire logic [15:0] i_sample,
    input  wire logic [15:0] q_sample,
    input  wire logic        last_of_buffer,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      rssi_db,
    output logic [16:0]      samples_averaged,
    output logic             power_zero,
    input  wire logic        offset_we,
    input  wire logic [15:0] offset_db
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SLW   = $clog2(SUM_W) + 16;
    localparam int CLW   = ((CNT_W > 1) ? $clog2(CNT_W) : 1) + 16;

    logic                     advance;
    logic [SUM_W-1:0]         snap_sum;
    logic [CNT_W-1:0]         snap_count;
    side_t                    snap_side;
    logic [SLW-1:0]           sum_log;
    logic [CLW-1:0]           cnt_log;
    side_t                    side_pipe_reg [4];
    logic signed [RSSI_W-1:0] offset_reg;
    logic                     fin_valid;
    result_t                  fin;
    result_t                  out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (offset_we)
        begin
            offset_reg <= offset_db;
        end
    end

    // Buffer information waits here while the log2 units work.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                side_pipe_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            side_pipe_reg[0] <= snap_side;
            for (int k = 1; k < 4; k++)
            begin
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
        end
    end

    iqpm_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .sample_valid   (sample_valid),
        .i_sample       (i_sample),
        .q_sample       (q_sample),
        .last_of_buffer (last_of_buffer),
        .snap_sum       (snap_sum),
        .snap_count     (snap_count),
        .snap_side      (snap_side)
    );

    iqpm_log2 #(
        .XW (SUM_W)
    ) u_log_sum (
        .clk     (clk),
        .advance (advance),
        .x       (snap_sum),
        .log_q16 (sum_log)
    );

    iqpm_log2 #(
        .XW (CNT_W)
    ) u_log_cnt (
        .clk     (clk),
        .advance (advance),
        .x       (snap_count),
        .log_q16 (cnt_log)
    );

    iqpm_db #(
        .SLW (SLW),
        .CLW (CLW)
    ) u_db (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .sum_log   (sum_log),
        .cnt_log   (cnt_log),
        .side_in   (side_pipe_reg[3]),
        .offset    (offset_reg),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    iqpm_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (fin_valid),
        .push_data    (fin),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_data     (out_data)
    );

    assign sample_stall     = !advance;
    assign rssi_db          = out_data.rssi;
    assign samples_averaged = out_data.count;
    assign power_zero       = out_data.zero;

endmodule

`default_nettype wire

### hdl/iqpm_accum.sv
`default_nettype none

module iqpm_accum
    import iqpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 65536,
    parameter int CNT_W       = 17
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   sample_valid,
    input  wire logic [15:0]            i_sample,
    input  wire logic [15:0]            q_sample,
    input  wire logic                   last_of_buffer,
    output logic      [SUM_W-1:0]       snap_sum,
    output logic      [CNT_W-1:0]       snap_count,
    output side_t                       snap_side
);

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                          in_valid_reg;
    logic                          in_last_reg;
    logic signed [SAMPLE_BITS-1:0] in_i_reg;
    logic signed [SAMPLE_BITS-1:0] in_q_reg;

    logic                          sq_valid_reg;
    logic                          sq_last_reg;
    logic        [SQ_W-1:0]        ii_reg;
    logic        [SQ_W-1:0]        qq_reg;
    logic signed [SQ_W-1:0]        ii_full;
    logic signed [SQ_W-1:0]        qq_full;

    logic        [SUM_W-1:0]       sum_reg;
    logic        [SUM_W-1:0]       sum_next;
    logic        [CNT_W-1:0]       cnt_reg;
    logic        [CNT_W-1:0]       cnt_next;
    logic                          room;
    logic        [SUM_W:0]         total;
    logic        [SUM_W-1:0]       add_sum;
    logic        [CNT_W-1:0]       add_cnt;
    logic        [CNT_W+16:0]      cnt_wide;

    logic                          snap_valid_reg;
    logic                          snap_zero_reg;
    logic        [CNT_OUT_W-1:0]   snap_cnt17_reg;
    logic        [SUM_W-1:0]       snap_sum_reg;
    logic        [CNT_W-1:0]       snap_cnt_reg;

    function automatic logic [SAMPLE_BITS-1:0] in_i_reg_src(input logic [15:0] word);
        return word[SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (advance)
            begin
                in_valid_reg   <= sample_valid;
                sq_valid_reg   <= in_valid_reg;
                snap_valid_reg <= sq_valid_reg & sq_last_reg;
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // Only the low SAMPLE_BITS bits of each converter word carry the sample.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_i_reg    <= in_i_reg_src(i_sample);
            in_q_reg    <= in_i_reg_src(q_sample);
            in_last_reg <= last_of_buffer;
            ii_reg      <= ii_full;
            qq_reg      <= qq_full;
            sq_last_reg <= in_last_reg;
        end
    end

    assign ii_full = SQ_W'(in_i_reg) * SQ_W'(in_i_reg);
    assign qq_full = SQ_W'(in_q_reg) * SQ_W'(in_q_reg);

    // Samples beyond a full buffer are dropped until the buffer is closed.
    always_comb
    begin
        room    = cnt_reg < CNT_W'(MAX_SAMPLES);
        total   = {1'b0, sum_reg} + (SUM_W+1)'(ii_reg) + (SUM_W+1)'(qq_reg);
        add_sum = room ? (total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0]) : sum_reg;
        add_cnt = room ? cnt_reg + CNT_W'(1) : cnt_reg;
        cnt_wide = (CNT_W+17)'(add_cnt);
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (advance && sq_valid_reg)
        begin
            if (sq_last_reg)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = add_sum;
                cnt_next = add_cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            snap_sum_reg   <= add_sum;
            snap_cnt_reg   <= add_cnt;
            snap_zero_reg  <= (add_sum == '0);
            snap_cnt17_reg <= cnt_wide[CNT_OUT_W-1:0];
        end
    end

    assign snap_sum        = snap_sum_reg;
    assign snap_count      = snap_cnt_reg;
    assign snap_side.valid = snap_valid_reg;
    assign snap_side.zero  = snap_zero_reg;
    assign snap_side.count = snap_cnt17_reg;

endmodule

`default_nettype wire

### hdl/iqpm_log2.sv
`default_nettype none

module iqpm_log2
    import iqpm_pkg::*;
#(
    parameter int XW = 48
)
(
    input  wire logic                  clk,
    input  wire logic                  advance,
    input  wire logic [XW-1:0]         x,
    output logic      [((XW > 1) ? $clog2(XW) : 1) + 15:0] log_q16
);

    localparam int EW = (XW > 1) ? $clog2(XW) : 1;
    localparam int LW = EW + 16;

    logic [XW-1:0]    x1_reg;
    logic [EW-1:0]    e1_reg;
    logic [XW+15:0]   norm;
    logic [EW-1:0]    e2_reg;
    logic [15:0]      m2_reg;
    logic [16:0]      base17;
    logic [16:0]      step17;
    logic [24:0]      prod;
    logic [EW-1:0]    e3_reg;
    logic [15:0]      base3_reg;
    logic [12:0]      frac3_reg;
    logic [16:0]      lo17;
    logic [LW-1:0]    log_reg;

    function automatic logic [EW-1:0] lead_one(input logic [XW-1:0] v);
        logic [EW-1:0] pos;
        pos = '0;
        for (int k = 0; k < XW; k++)
        begin
            if (v[k])
            begin
                pos = EW'(k);
            end
        end
        return pos;
    endfunction

    function automatic logic [EW-1:0] e2_src(input logic [EW-1:0] e);
        return e;
    endfunction

    // The 16 bits just below the leading one, zero-filled for small values.
    assign norm = {x1_reg, 16'h0000} >> e2_src(e1_reg);

    // Linear interpolation between table points on the top four mantissa bits.
    always_comb
    begin
        base17 = log_tab({1'b0, m2_reg[15:12]});
        step17 = log_tab({1'b0, m2_reg[15:12]} + 5'd1) - base17;
        prod   = 25'(step17[12:0]) * 25'(m2_reg[11:0]);
        lo17   = 17'(base3_reg) + 17'(frac3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg    <= x;
            e1_reg    <= lead_one(x);
            e2_reg    <= e1_reg;
            m2_reg    <= norm[15:0];
            e3_reg    <= e2_reg;
            base3_reg <= base17[15:0];
            frac3_reg <= prod[24:12];
            log_reg   <= {e3_reg, lo17[15:0]};
        end
    end

    assign log_q16 = log_reg;

endmodule

`default_nettype wire

### hdl/iqpm_db.sv
`default_nettype none

module iqpm_db
    import iqpm_pkg::*;
#(
    parameter int SLW = 22,
    parameter int CLW = 21
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [SLW-1:0]           sum_log,
    input  wire logic [CLW-1:0]           cnt_log,
    input  wire side_t                    side_in,
    input  wire logic signed [RSSI_W-1:0] offset,
    output logic                          fin_valid,
    output result_t                       fin
);

    localparam int D_W = ((SLW > CLW) ? SLW : CLW) + 1;
    localparam int P_W = D_W + 19;
    localparam int U_W = P_W - 24;
    localparam int Q_W = U_W + 1;

    localparam logic signed [18:0]    DB_K   = 19'(DB_PER_LOG2);
    localparam logic signed [P_W-1:0] HALF   = P_W'(1 << 23);
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(RSSI_MAX);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(RSSI_MIN);

    logic signed [D_W-1:0]  d_next;
    logic signed [D_W-1:0]  d_reg;
    side_t                  side_d_reg;
    logic signed [P_W-1:0]  p_next;
    logic signed [P_W-1:0]  p_reg;
    side_t                  side_p_reg;
    logic signed [P_W-1:0]  rnd;
    logic signed [U_W-1:0]  u;
    logic signed [Q_W-1:0]  sum_q;
    logic        [RSSI_W-1:0] rssi_next;
    logic                   fin_valid_reg;
    result_t                fin_reg;

    assign d_next = $signed(D_W'(sum_log)) - $signed(D_W'(cnt_log));
    assign p_next = P_W'(d_reg) * P_W'(DB_K);

    // Round to nearest Q8.8, add the offset and clamp to 16 bits; a zero sum gives the floor.
    always_comb
    begin
        rnd   = p_reg + HALF;
        u     = $signed(rnd[P_W-1:24]);
        sum_q = Q_W'(u) + Q_W'(offset);
        if (side_p_reg.zero)
        begin
            rssi_next = RSSI_MIN;
        end
        else if (sum_q > SAT_HI)
        begin
            rssi_next = RSSI_MAX;
        end
        else if (sum_q < SAT_LO)
        begin
            rssi_next = RSSI_MIN;
        end
        else
        begin
            rssi_next = sum_q[RSSI_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_d_reg    <= '0;
            side_p_reg    <= '0;
            fin_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            side_d_reg    <= side_in;
            side_p_reg    <= side_d_reg;
            fin_valid_reg <= side_p_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg         <= d_next;
            p_reg         <= p_next;
            fin_reg.rssi  <= rssi_next;
            fin_reg.count <= side_p_reg.count;
            fin_reg.zero  <= side_p_reg.zero;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

`default_nettype wire

### hdl/iqpm_outq.sv
`default_nettype none

module iqpm_outq
    import iqpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire result_t push_data,
    output logic         advance,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_reg;
    result_t skid_reg;
    logic    push;
    logic    take;

    // The pipeline moves only while the skid register is empty.
    assign advance = !skid_valid_reg;
    assign push    = advance && push_valid;
    assign take    = out_valid_reg && !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_data     = out_reg;

endmodule

`default_nettype wire

### hdl/iqpm_checker.sv
`default_nettype none

module iqpm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        sample_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [15:0] rssi_db,
    input wire logic [16:0] samples_averaged,
    input wire logic        power_zero
);

    // A result held back by the receiver stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(rssi_db)
            && $stable(samples_averaged) && $stable(power_zero))
        else $error("result changed while stalled");

    // An empty buffer power always reports the floor value.
    a_zero_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && power_zero |-> rssi_db == 16'h8000)
        else $error("zero power without floor rssi");

    // The input only backs up when a result is already waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // The skid register fills only when the output register was held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(result_valid && result_stall))
        else $error("input stall without output backpressure");

endmodule

bind iq_rssi_power_meter_unit iqpm_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_stall     (sample_stall),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .rssi_db          (rssi_db),
    .samples_averaged (samples_averaged),
    .power_zero       (power_zero)
);

`default_nettype wire

### test/tb_iq_rssi_power_meter_unit.sv
`timescale 1ns / 100ps

module tb_iq_rssi_power_meter_unit;

    localparam int          MAX_SAMPLES     = 65536;
    localparam logic [47:0] SUM_CEILING     = 48'hFFFF_FFFF_FFFF;
    // 10*log10(2) in Q.16, turns a log2 difference into dB.
    localparam longint      DB_PER_OCTAVE   = 197283;
    localparam logic [15:0] OFFSET_AT_RESET = 16'hD67F;     // -10625 in Q8.8
    localparam logic [15:0] RSSI_FLOOR      = 16'h8000;
    // One full-scale sample on both rails with the reset offset: 23890 - 10625.
    localparam logic [15:0] RSSI_FULL_SCALE = 16'd13265;
    localparam int          RUN_LIMIT       = 1000000;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          PHASE_ITEMS     = 285;

    localparam int unsigned LOG_FRAC [17] = '{
        0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
        42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
    };

    typedef struct packed {
        logic [15:0] rssi;
        logic [16:0] count;
        logic        zero;
    } reading_t;

    typedef struct packed {
        logic [15:0] i_word;
        logic [15:0] q_word;
        logic        last;
        logic        fixed;     // the reading below is checked instead of a predicted one
        reading_t    want;
    } probe_t;

    typedef enum int {AMP_ZERO, AMP_SPARSE, AMP_SMALL, AMP_EXTREME, AMP_FULL} amp_kind_t;

    localparam int PROBE_ROWS = 19;
    localparam probe_t PROBES [PROBE_ROWS] = '{
        '{16'h0000, 16'h0000, 1'b1, 1'b1, '{RSSI_FLOOR, 17'd1, 1'b1}},
        '{16'h0001, 16'h0000, 1'b1, 1'b1, '{OFFSET_AT_RESET, 17'd1, 1'b0}},
        '{16'h8000, 16'h8000, 1'b1, 1'b1, '{RSSI_FULL_SCALE, 17'd1, 1'b0}},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 16'h0000, 1'b1, 1'b1, '{RSSI_FLOOR, 17'd2, 1'b1}},
        '{16'h7FFF, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 16'h7FFF, 1'b1, 1'b0, '0},
        '{16'hFFFF, 16'h0001, 1'b1, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b1, 1'b0, '0},
        '{16'h0000, 16'h0001, 1'b0, 1'b0, '0},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, '0},
        '{16'h1234, 16'h8765, 1'b1, 1'b0, '0},
        '{16'h0001, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 16'hFFFF, 1'b1, 1'b0, '0},
        '{16'h8001, 16'h7FFF, 1'b1, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        sample_valid   = 1'b0;
    logic        sample_stall;
    logic [15:0] i_sample       = '0;
    logic [15:0] q_sample       = '0;
    logic        last_of_buffer = 1'b0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    logic [15:0] rssi_db;
    logic [16:0] samples_averaged;
    logic        power_zero;
    logic        offset_we      = 1'b0;
    logic [15:0] offset_db      = '0;

    // Predictor state.
    logic [47:0] acc_power  = '0;
    logic [16:0] acc_count  = '0;
    logic [15:0] offset_now = OFFSET_AT_RESET;

    reading_t readings_due [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       steady_flow    = 1'b0;
    bit       hold_wanted    = 1'b0;
    bit       hold_done      = 1'b0;

    iq_rssi_power_meter_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .i_sample         (i_sample),
        .q_sample         (q_sample),
        .last_of_buffer   (last_of_buffer),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .rssi_db          (rssi_db),
        .samples_averaged (samples_averaged),
        .power_zero       (power_zero),
        .offset_we        (offset_we),
        .offset_db        (offset_db)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Q.16 log2 from the leading one and an interpolated table of the 16 bits below it.
    function automatic longint log2_fix(input logic [63:0] x);
        int          e;
        logic [15:0] m;
        int unsigned base;
        int unsigned step;
        e = 63;
        while (e > 0 && !x[e])
            e--;
        if (e >= 16)
            m = 16'(x >> (e - 16));
        else
            m = 16'(x << (16 - e));
        base = LOG_FRAC[m[15:12]];
        step = LOG_FRAC[m[15:12] + 1] - base;
        return longint'(e) * 65536 + longint'(base) + longint'((step * m[11:0]) >> 12);
    endfunction

    function automatic bit meter_predict(input logic [15:0] i_word, input logic [15:0] q_word,
                                         input logic last, output reading_t r);
        longint      iv;
        longint      qv;
        longint      d;
        longint      db;
        logic [48:0] total;
        r = '0;
        if (acc_count < MAX_SAMPLES)
        begin
            iv = $signed(i_word);
            qv = $signed(q_word);
            total = {1'b0, acc_power} + 49'(iv * iv + qv * qv);
            acc_power = (total > {1'b0, SUM_CEILING}) ? SUM_CEILING : total[47:0];
            acc_count = acc_count + 1'b1;
        end
        if (!last)
            return 1'b0;
        if (acc_power == 0)
        begin
            r.rssi = RSSI_FLOOR;
            r.zero = 1'b1;
        end
        else
        begin
            d  = log2_fix(acc_power) - log2_fix(acc_count);
            db = ((d * DB_PER_OCTAVE + (64'sd1 <<< 23)) >>> 24) + $signed(offset_now);
            if (db > 32767)
                db = 32767;
            else if (db < -32768)
                db = -32768;
            r.rssi = 16'(db);
        end
        r.count   = acc_count;
        acc_power = '0;
        acc_count = '0;
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_word(input amp_kind_t kind);
        logic [15:0] w;
        case (kind)
            AMP_ZERO:
                w = '0;
            AMP_SPARSE:
                if ($urandom_range(0, 7) != 0)
                    w = 16'h0000;
                else
                    w = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            AMP_SMALL:
                w = 16'($urandom_range(0, 512)) - 16'd256;
            AMP_EXTREME:
                case ($urandom_range(0, 3))
                    0:       w = 16'h8000;
                    1:       w = 16'h7FFF;
                    2:       w = 16'h8001;
                    default: w = 16'hFFFF;
                endcase
            default:
                w = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_sample(input logic [15:0] i_word, input logic [15:0] q_word,
                               input logic last, input logic fixed = 1'b0,
                               input reading_t fixed_want = '0);
        reading_t predicted;
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < 33)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        i_sample       = i_word;
        q_sample       = q_word;
        last_of_buffer = last;
        sample_valid   = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (meter_predict(i_word, q_word, last, predicted))
            readings_due.push_back(fixed ? fixed_want : predicted);
    endtask

    // Writes happen only once the pipeline has drained; a buffer still open holds no result.
    task automatic load_offset(input logic [15:0] value);
        @(negedge clk);
        sample_valid = 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        offset_we = 1'b1;
        offset_db = value;
        @(negedge clk);
        offset_we  = 1'b0;
        offset_now = value;
    endtask

    // Receiver: random stall, plus one long hold-off so the output side backs up.
    always
    begin
        @(negedge clk);
        if (hold_wanted && !hold_done)
        begin
            hold_done    = 1'b1;
            result_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        else
            result_stall = !steady_flow && ($urandom_range(0, 99) < 33);
    end

    always @(posedge clk)
    begin : check_reading
        reading_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (readings_due.size() == 0)
                flag_mismatch($sformatf("reading with none expected: rssi %h count %0d zero %b",
                                        rssi_db, samples_averaged, power_zero));
            else
            begin
                due = readings_due.pop_front();
                if (rssi_db !== due.rssi)
                    flag_mismatch($sformatf("rssi_db %h, expected %h", rssi_db, due.rssi));
                if (samples_averaged !== due.count)
                    flag_mismatch($sformatf("samples_averaged %0d, expected %0d",
                                            samples_averaged, due.count));
                if (power_zero !== due.zero)
                    flag_mismatch($sformatf("power_zero %b, expected %b", power_zero, due.zero));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("[iq_rssi_power_meter_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] offsets [6];
        int          phase_items;
        int          len;
        int          pick;
        amp_kind_t   kind;
        offsets = '{16'h7FFF, 16'h8000, 16'h0000, 16'($urandom), 16'($urandom), OFFSET_AT_RESET};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (PROBES[k])
            push_sample(PROBES[k].i_word, PROBES[k].q_word, PROBES[k].last,
                        PROBES[k].fixed, PROBES[k].want);

        foreach (offsets[p])
        begin
            load_offset(offsets[p]);
            steady_flow = (p == 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (p == 1 && phase_items >= 100)
                    hold_wanted = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    len = 1;
                else if (pick < 70)
                    len = $urandom_range(2, 6);
                else if (pick < 90)
                    len = $urandom_range(7, 30);
                else
                    len = $urandom_range(31, 120);
                kind = amp_kind_t'($urandom_range(0, 4));
                for (int n = 1; n <= len; n++)
                    push_sample(pick_word(kind), pick_word(kind), n == len);
                phase_items += len;
            end
        end
        steady_flow = 1'b0;

        @(negedge clk);
        sample_valid = 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[iq_rssi_power_meter_unit] OK");
        else
            $display("[iq_rssi_power_meter_unit] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/iqpm_pkg.sv
hdl/iqpm_accum.sv
hdl/iqpm_log2.sv
hdl/iqpm_db.sv
hdl/iqpm_outq.sv
hdl/iq_rssi_power_meter_unit.sv
hdl/iqpm_checker.sv
test/tb_iq_rssi_power_meter_unit.sv
